// ----- hw/rtl/hps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants for the percentile stretch core
// Register codes, controller states and controller/datapath command structs.
// ----------------------------------------------------------------------------
package hps_pkg;

	localparam int BinLog2   = 16;
	localparam int FrameLog2 = 20;
	localparam int NumBins   = 1 << BinLog2;
	localparam int BinShift  = 16 - BinLog2;
	localparam int CntW      = FrameLog2 + 1;
	localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

	localparam logic [1:0] RegFormat = 2'd0;
	localparam logic [1:0] RegMode   = 2'd1;
	localparam logic [1:0] RegNoise  = 2'd2;
	localparam logic [1:0] RegSkip   = 2'd3;

	localparam logic [1:0] FmtByte = 2'd0;
	localparam logic [1:0] FmtU16  = 2'd1;
	localparam logic [1:0] FmtS16  = 2'd2;

	localparam logic [1:0] ModeAuto    = 2'd0;
	localparam logic [1:0] ModeNone    = 2'd1;
	localparam logic [1:0] ModeLinear  = 2'd2;
	localparam logic [1:0] ModeAutoAlt = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MAP_DIV,
		ST_MAP_OUT,
		ST_THR,
		ST_SCAN_LO,
		ST_SCAN_HI,
		ST_FINISH,
		ST_REPORT
	} hps_state_t;

	typedef struct packed {
		logic clr_step;
		logic load_rd;
		logic load_wr;
		logic map_start;
		logic map_step;
		logic thr_step;
		logic scan_lo_init;
		logic scan_lo_step;
		logic scan_hi_init;
		logic scan_hi_step;
		logic finish;
		logic out_map;
		logic out_rep;
	} hps_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_map;
		logic is_last;
		logic map_fast;
		logic div_done;
		logic thr_done;
		logic lo_done;
		logic hi_done;
	} hps_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hps_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hps_ctrl: sequencer
// Steps the datapath through clear, load, map and range scan phases.
// ----------------------------------------------------------------------------
module hps_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  hps_pkg::hps_stat_t stat,
	output logic             busy,
	output hps_pkg::hps_cmd_t  cmd
);

	hps_pkg::hps_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hps_pkg::ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hps_pkg::ST_CLEAR: if (stat.clr_done) state_d = hps_pkg::ST_IDLE;
			hps_pkg::ST_IDLE: begin
				if (start) begin
					if (stat.is_map) state_d = stat.map_fast ? hps_pkg::ST_MAP_OUT
						: hps_pkg::ST_MAP_DIV;
					else state_d = hps_pkg::ST_LOAD;
				end
			end
			hps_pkg::ST_LOAD: state_d = stat.is_last ? hps_pkg::ST_THR : hps_pkg::ST_IDLE;
			hps_pkg::ST_MAP_DIV: if (stat.div_done) state_d = hps_pkg::ST_MAP_OUT;
			hps_pkg::ST_MAP_OUT: state_d = hps_pkg::ST_IDLE;
			hps_pkg::ST_THR: if (stat.thr_done) state_d = hps_pkg::ST_SCAN_LO;
			hps_pkg::ST_SCAN_LO: if (stat.lo_done) state_d = hps_pkg::ST_SCAN_HI;
			hps_pkg::ST_SCAN_HI: if (stat.hi_done) state_d = hps_pkg::ST_FINISH;
			hps_pkg::ST_FINISH: state_d = hps_pkg::ST_REPORT;
			hps_pkg::ST_REPORT: state_d = hps_pkg::ST_CLEAR;
			default: state_d = hps_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			hps_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			hps_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load_rd = start & ~stat.is_map;
				cmd.map_start = start & stat.is_map;
			end
			hps_pkg::ST_LOAD: begin
				cmd.load_wr = 1'b1;
				cmd.scan_lo_init = stat.is_last;
			end
			hps_pkg::ST_MAP_DIV: cmd.map_step = 1'b1;
			hps_pkg::ST_MAP_OUT: cmd.out_map = 1'b1;
			hps_pkg::ST_THR: cmd.thr_step = 1'b1;
			hps_pkg::ST_SCAN_LO: begin
				cmd.scan_lo_step = 1'b1;
				cmd.scan_hi_init = stat.lo_done;
			end
			hps_pkg::ST_SCAN_HI: cmd.scan_hi_step = 1'b1;
			hps_pkg::ST_FINISH: cmd.finish = 1'b1;
			hps_pkg::ST_REPORT: cmd.out_rep = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/hps_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hps_dp: datapath
// Histogram memory, min/max, threshold multiply, tail scans, map divider.
// ----------------------------------------------------------------------------
module hps_dp (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                kind,
	input  wire signed [16:0]  sample,
	input  wire                last,
	input  wire  [1:0]         fmt,
	input  wire  [1:0]         mode,
	input  wire  [19:0]        noise,
	input  wire  [7:0]         skip,
	input  hps_pkg::hps_cmd_t  cmd,
	output hps_pkg::hps_stat_t stat,
	output logic               result_valid,
	output logic               result_kind,
	output logic [7:0]         mapped,
	output logic signed [16:0] range_low,
	output logic signed [16:0] range_high
);

	localparam int BW = hps_pkg::BinLog2;
	localparam int CW = hps_pkg::CntW;
	localparam int TW = CW + 21; // threshold plus one bin of headroom

	logic [CW-1:0] mem [hps_pkg::NumBins];
	logic [CW-1:0] rd_q;
	logic [BW-1:0] addr;
	logic          we;
	logic [CW-1:0] wdata;

	logic [BW:0]   clr_q;
	logic [BW-1:0] bin_q;
	logic signed [16:0] min_q, max_q, lo_q, hi_q, slo_q, shi_q;
	logic [CW-1:0] total_q;
	logic          last_q;
	logic [TW-1:0] thr_q;
	logic [TW-1:0] acc_q; // running tail count times 1e6
	logic [BW:0]   ptr_q;
	logic          pend_q; // scan has no bins to visit
	logic [7:0]    mapped_q;
	logic          rep_q, mfast_q;

	// decode input
	logic [15:0] u, key;
	logic signed [16:0] v;
	always_comb begin
		u = sample[15:0];
		case (fmt)
			hps_pkg::FmtByte: begin key = {8'd0, u[7:0]}; v = {9'd0, u[7:0]}; end
			hps_pkg::FmtS16: begin key = u ^ 16'h8000; v = {u[15], u}; end
			default: begin key = u; v = {1'b0, u}; end
		endcase
	end

	function automatic logic signed [16:0] bin_val(input logic [BW-1:0] b,
			input logic [1:0] f);
		logic [16:0] x;
		x = 17'(b) << hps_pkg::BinShift;
		return (f == hps_pkg::FmtS16) ? $signed(x) - 17'sd32768 : $signed(x);
	endfunction

	// memory address select
	logic [BW:0] top;
	assign top = (BW+1)'(hps_pkg::NumBins - 1) - (BW+1)'(skip);
	always_comb begin
		we = 1'b0;
		wdata = rd_q + ((rd_q != hps_pkg::CountMax) ? CW'(1) : CW'(0));
		addr = bin_q;
		if (cmd.clr_step) begin
			we = 1'b1; wdata = '0; addr = clr_q[BW-1:0];
		end else if (cmd.load_rd) begin
			addr = key[15 -: BW];
		end else if (cmd.load_wr) begin
			we = 1'b1;
		end else if (cmd.scan_lo_init || cmd.thr_step) begin
			addr = BW'(skip);
		end else if (cmd.scan_hi_init) begin
			addr = top[BW-1:0];
		end else begin
			addr = ptr_q[BW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	// map division: restoring, one quotient bit a cycle
	logic signed [19:0] d_s;
	logic signed [27:0] n2;
	logic [27:0] rem_q, den_q;
	logic [8:0]  quo_q;
	logic [3:0]  dcnt_q;
	logic [1:0]  emode;
	logic        lin;
	logic [7:0]  fast_val;
	logic        fast;
	always_comb begin
		emode = mode;
		if (mode == hps_pkg::ModeAuto || mode == hps_pkg::ModeAutoAlt)
			emode = (fmt == hps_pkg::FmtByte) ? hps_pkg::ModeNone : hps_pkg::ModeLinear;
		lin = (emode != hps_pkg::ModeNone);
		d_s = 20'(shi_q) - 20'(slo_q);
		n2 = 28'sd510 * (28'(v) - 28'(slo_q)) + 28'(d_s);
		fast = 1'b1;
		fast_val = 8'd0;
		if (!lin) fast_val = (fmt == hps_pkg::FmtByte) ? v[7:0] : 8'd0;
		else if (d_s <= 0) fast_val = (v > slo_q) ? 8'd255 : 8'd0;
		else if (n2 < 0) fast_val = 8'd0;
		else fast = 1'b0;
	end

	// first step tests for a quotient of 256 or more, then 8 quotient bits
	logic qbit;
	assign qbit = (rem_q >= den_q);

	// scan accumulate
	logic [TW-1:0] mul;
	logic [TW-1:0] acc_n;
	assign mul = TW'(rd_q) * TW'(20'd1000000);
	assign acc_n = acc_q + mul;
	logic hit;
	assign hit = acc_n > thr_q;

	// status
	assign stat.clr_done = clr_q[BW];
	assign stat.is_map = kind;
	assign stat.is_last = last_q;
	assign stat.map_fast = fast;
	assign stat.div_done = (dcnt_q == 4'd1);
	assign stat.thr_done = 1'b1;
	assign stat.lo_done = hit || ptr_q[BW] || pend_q;
	assign stat.hi_done = hit || ptr_q[BW] || pend_q;

	// final range: raw min/max; byte 0..255 if equal, 16-bit full if empty
	logic signed [16:0] fin_lo, fin_hi;
	always_comb begin
		fin_lo = lo_q;
		fin_hi = hi_q;
		if (fmt == hps_pkg::FmtByte) begin
			if (lo_q == hi_q) begin fin_lo = '0; fin_hi = 17'sd255; end
		end else if (hi_q <= lo_q) begin
			if (fmt == hps_pkg::FmtS16) begin fin_lo = -17'sd32768; fin_hi = 17'sd32767; end
			else begin fin_lo = '0; fin_hi = 17'sd65535; end
		end
	end

	logic [BW:0] ptr_n;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			slo_q <= '0; shi_q <= 17'sd65535;
			result_valid <= 1'b0;
			min_q <= 17'sd65535; max_q <= -17'sd32768; total_q <= '0;
			dcnt_q <= '0;
		end else begin
			result_valid <= cmd.out_map | cmd.out_rep;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (cmd.load_rd) begin
				if (v < min_q) min_q <= v;
				if (v > max_q) max_q <= v;
				if (total_q != hps_pkg::CountMax) total_q <= total_q + 1'b1;
			end
			if (cmd.map_start) dcnt_q <= 4'd9;
			else if (cmd.map_step && dcnt_q != 0) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.finish) begin
				slo_q <= fin_lo; shi_q <= fin_hi;
				min_q <= 17'sd65535; max_q <= -17'sd32768; total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rd) begin bin_q <= key[15 -: BW]; last_q <= last; end
		if (cmd.thr_step) thr_q <= TW'(noise) * TW'(total_q);
		if (cmd.map_start) begin
			mapped_q <= fast_val;
			rem_q <= 28'(n2); den_q <= 28'({d_s, 9'd0});
			quo_q <= '0;
		end else if (cmd.map_step && dcnt_q != 0) begin
			den_q <= den_q >> 1;
			if (dcnt_q == 4'd9) begin
				quo_q[8] <= qbit;
			end else begin
				quo_q[7:0] <= {quo_q[6:0], qbit};
				if (qbit) rem_q <= rem_q - den_q;
			end
		end
		// rd_q holds bin ptr_q-1 on the upward scan, ptr_q+1 on the downward one
		if (cmd.scan_lo_step) begin
			acc_q <= acc_n;
			ptr_q <= ptr_n;
			if (hit && !pend_q && fmt != hps_pkg::FmtByte)
				lo_q <= bin_val(ptr_q[BW-1:0] - 1'b1, fmt);
		end
		if (cmd.scan_hi_step) begin
			acc_q <= acc_n;
			ptr_q <= ptr_q - 1'b1;
			if (hit && !pend_q && fmt != hps_pkg::FmtByte)
				hi_q <= bin_val(ptr_q[BW-1:0] + 1'b1, fmt);
		end
		// init follows the steps so the hi init wins on the last lo step
		if (cmd.scan_lo_init || cmd.scan_hi_init) begin
			acc_q <= '0;
			pend_q <= cmd.scan_hi_init ? top[BW] : 1'b0;
			ptr_q <= cmd.scan_hi_init ? (top - 1'b1) : ((BW+1)'(skip) + 1'b1);
			if (cmd.scan_lo_init) lo_q <= min_q;
			if (cmd.scan_hi_init) hi_q <= max_q;
		end
	end
	assign ptr_n = ptr_q + 1'b1;

	// result fields
	always_comb begin
		result_kind = 1'b1;
		mapped = 8'd0;
		range_low = slo_q;
		range_high = shi_q;
		if (!rep_q) begin
			result_kind = 1'b0;
			mapped = mfast_q ? mapped_q : ((quo_q > 9'd255) ? 8'd255 : quo_q[7:0]);
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.out_rep) rep_q <= 1'b1;
		if (cmd.out_map) rep_q <= 1'b0;
		if (cmd.map_start) mfast_q <= fast;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/histogram_percentile_stretch_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_percentile_stretch_core: percentile-clipped contrast stretch
// Histogram load, end-of-frame tail scan, linear remap of samples.
//
// channel | signals                              | beat
// in      | start busy kind sample last          | start & !busy
// out     | result_valid result_kind mapped ...  | result_valid, one cycle
// cfg     | psel penable pwrite paddr pwdata ... | psel&penable&pwrite
//
// Load is a memory read-modify-write. Map either goes straight to output or runs the divider.
// Last load adds threshold, two tail scans (one bin a cycle, up to 65536
// bins each) and a clear pass over all 65536 bins.
// After reset the clear pass runs before busy drops.
// Results are single-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module histogram_percentile_stretch_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire               kind,
	input  wire signed [16:0] sample,
	input  wire               last,
	output logic              result_valid,
	output logic              result_kind,
	output logic [7:0]        mapped,
	output logic signed [16:0] range_low,
	output logic signed [16:0] range_high,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [3:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [1:0]  fmt_q, mode_q;
	logic [19:0] noise_q;
	logic [7:0]  skip_q;
	hps_pkg::hps_cmd_t  cmd;
	hps_pkg::hps_stat_t stat;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= hps_pkg::FmtU16; mode_q <= hps_pkg::ModeAuto;
			noise_q <= 20'd2000; skip_q <= 8'd10;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				hps_pkg::RegFormat: fmt_q <= pwdata[1:0];
				hps_pkg::RegMode: mode_q <= pwdata[1:0];
				hps_pkg::RegNoise: noise_q <= pwdata[19:0];
				hps_pkg::RegSkip: skip_q <= pwdata[7:0];
				default: fmt_q <= fmt_q;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			hps_pkg::RegFormat: prdata = {30'd0, fmt_q};
			hps_pkg::RegMode: prdata = {30'd0, mode_q};
			hps_pkg::RegNoise: prdata = {12'd0, noise_q};
			hps_pkg::RegSkip: prdata = {24'd0, skip_q};
			default: prdata = '0;
		endcase
	end

	hps_ctrl u_ctrl (.clk, .arst_n, .start, .stat, .busy, .cmd);

	hps_dp u_dp (.clk, .arst_n, .kind, .sample, .last, .fmt(fmt_q),
		.mode(mode_q), .noise(noise_q), .skip(skip_q), .cmd, .stat,
		.result_valid, .result_kind, .mapped, .range_low, .range_high);

endmodule
`default_nettype wire
